FILE: sv/hhbp_pkg.sv
package hhbp_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int LIMIT_W         = 16;
    localparam int CFG_INDEX_W     = 1;
    localparam int BYTE_W          = 8;

    localparam logic [LIMIT_W-1:0] KEY_LIMIT_RST   = 16'd256;
    localparam logic [LIMIT_W-1:0] VALUE_LIMIT_RST = 16'd8192;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_LIMIT   = 1'b0,
        REG_VALUE_LIMIT = 1'b1
    } t_reg_index;

    typedef enum logic [5:0] {
        PH_LINE     = 6'b000001,
        PH_BLOCK_CR = 6'b000010,
        PH_KEY      = 6'b000100,
        PH_VALUE    = 6'b001000,
        PH_VALUE_CR = 6'b010000,
        PH_AFTER_LF = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        EV_KEY_BYTE   = 3'd0,
        EV_KEY_END    = 3'd1,
        EV_VALUE_BYTE = 3'd2,
        EV_FIELD_END  = 3'd3,
        EV_BLOCK_END  = 3'd4,
        EV_ERROR      = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_KEY_LONG    = 3'd1,
        ERR_BAD_KEY     = 3'd2,
        ERR_NO_LF       = 3'd3,
        ERR_VALUE_LONG  = 3'd4,
        ERR_BARE_LF     = 3'd5,
        ERR_BAD_VALUE   = 3'd6,
        ERR_BAD_REQUEST = 3'd7
    } t_error;

    typedef struct packed {
        t_event            kind;
        logic [BYTE_W-1:0] data;
        t_error            err;
        logic              last;
    } t_result;

    function automatic t_result make_result(input t_event k, input logic [BYTE_W-1:0] d,
                                            input t_error e);
        t_result r;
        r.kind = k;
        r.data = d;
        r.err  = e;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_tchar(input logic [BYTE_W-1:0] c);
        logic r;
        case (c) inside
            [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/hhbp_cfg_if.sv
interface hhbp_cfg_if import hhbp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [LIMIT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/hhbp_in_if.sv
interface hhbp_in_if import hhbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, in_byte, input ready);
    modport sink   (input valid, in_byte, output ready);
endinterface

FILE: sv/hhbp_out_if.sv
interface hhbp_out_if import hhbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        event_kind;
    logic [BYTE_W-1:0] out_byte;
    logic [2:0]        error_code;
    logic              last_of_run;

    modport source (output valid, event_kind, out_byte, error_code, last_of_run, input ready);
    modport sink   (input valid, event_kind, out_byte, error_code, last_of_run, output ready);
endinterface

FILE: sv/http_header_block_parser.sv
// HTTP/1.1 header block parser. Takes one raw byte per input transfer and
// sends key bytes (case-normalized), key end, value bytes (blank runs folded
// to one space), field end, block end and numbered error events, one event
// per output transfer; last_of_run marks the final event of a byte. A byte
// passes an input register, combinational parsing logic, and a two-entry
// result queue that drives the output port. Bytes that give no event or one
// event stream at one per cycle while the output port takes events. A byte
// that gives two events (field end before a key byte or an error, or a
// folded space before a value byte) is parsed only once the result queue is
// empty, so a run of such bytes waits for the queue to drain between bytes.
// The user must write limits through the configuration port only while the
// block is idle; the block itself does not enforce this.
module http_header_block_parser import hhbp_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hhbp_cfg_if.sink    i_cfg,
    hhbp_in_if.sink     i_in,
    hhbp_out_if.source  o_out
);

    localparam int SUM_W = LENGTH_BITS + 1;
    localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

    logic [LIMIT_W-1:0]     r_key_limit;
    logic [LIMIT_W-1:0]     r_value_limit;
    logic                   r_in_valid;
    logic [BYTE_W-1:0]      r_in_byte;
    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [LENGTH_BITS-1:0] r_key_count;
    logic [LENGTH_BITS-1:0] n_key_count;
    logic [LENGTH_BITS-1:0] r_value_count;
    logic [LENGTH_BITS-1:0] n_value_count;
    logic                   r_pend;
    logic                   n_pend;
    logic                   r_prev;
    logic                   n_prev;
    t_result                r_q [2];
    t_result                n_q [2];
    logic [1:0]             r_q_cnt;
    logic [1:0]             n_q_cnt;

    logic [BYTE_W-1:0]      c;
    logic                   c_letter;
    logic                   c_tchar;
    logic                   c_ws;
    logic                   c_ctrl;
    logic [SUM_W-1:0]       key_next;
    logic [SUM_W-1:0]       val_next;
    logic                   key_long;
    logic                   val_long;
    logic                   ls_key_long;
    logic [BYTE_W-1:0]      key_out;
    logic [BYTE_W-1:0]      ls_key_out;
    logic                   do_ls;
    t_result                step_res [2];
    logic [1:0]             step_cnt;
    logic                   pop;
    logic                   fire;
    logic [1:0]             base;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_limit   <= KEY_LIMIT_RST;
            r_value_limit <= VALUE_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (t_reg_index'(i_cfg.index))
                REG_KEY_LIMIT:   r_key_limit   <= i_cfg.data;
                REG_VALUE_LIMIT: r_value_limit <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign c        = r_in_byte;
    assign c_letter = is_letter(c);
    assign c_tchar  = is_tchar(c);
    assign c_ws     = (c == CH_SPACE) || (c == CH_TAB);
    assign c_ctrl   = (c < CH_SPACE) || (c == CH_DEL);

    assign key_next    = {1'b0, r_key_count} + SUM_W'(1);
    assign val_next    = {1'b0, r_value_count} + SUM_W'(1) + SUM_W'(r_pend);
    assign key_long    = (CMP_W'(key_next) > CMP_W'(r_key_limit)) || key_next[LENGTH_BITS];
    assign val_long    = (CMP_W'(val_next) > CMP_W'(r_value_limit)) || val_next[LENGTH_BITS];
    assign ls_key_long = (r_key_limit == '0);
    assign key_out     = c_letter ? (r_prev ? (c | CASE_BIT) : (c & ~CASE_BIT)) : c;
    assign ls_key_out  = c_letter ? (c & ~CASE_BIT) : c;

    always_comb begin
        n_phase       = r_phase;
        n_key_count   = r_key_count;
        n_value_count = r_value_count;
        n_pend        = r_pend;
        n_prev        = r_prev;
        step_res[0]   = '0;
        step_res[1]   = '0;
        step_cnt      = 2'd0;
        do_ls         = 1'b0;

        unique case (r_phase)
            PH_LINE: begin
                do_ls = 1'b1;
            end
            PH_BLOCK_CR: begin
                step_res[0] = (c == CH_LF) ? make_result(EV_BLOCK_END, '0, ERR_NONE)
                                           : make_result(EV_ERROR, '0, ERR_NO_LF);
                step_cnt = 2'd1;
                n_phase  = PH_LINE;
                n_key_count   = '0;
                n_value_count = '0;
                n_pend = 1'b0;
                n_prev = 1'b0;
            end
            PH_KEY: begin
                step_cnt = 2'd1;
                if (c == CH_COLON) begin
                    step_res[0]   = make_result(EV_KEY_END, '0, ERR_NONE);
                    n_phase       = PH_VALUE;
                    n_value_count = '0;
                    n_pend        = 1'b0;
                end else if (c_tchar && !key_long) begin
                    step_res[0] = make_result(EV_KEY_BYTE, key_out, ERR_NONE);
                    n_key_count = key_next[LENGTH_BITS-1:0];
                    n_prev      = c_letter;
                end else begin
                    step_res[0] = make_result(EV_ERROR, '0,
                                              c_tchar ? ERR_KEY_LONG : ERR_BAD_KEY);
                    n_phase       = PH_LINE;
                    n_key_count   = '0;
                    n_value_count = '0;
                    n_pend = 1'b0;
                    n_prev = 1'b0;
                end
            end
            PH_VALUE: begin
                if (c == CH_CR) begin
                    n_phase = PH_VALUE_CR;
                end else if (c_ws) begin
                    n_pend = (r_value_count != '0);
                end else if (!c_ctrl && !val_long) begin
                    if (r_pend) begin
                        step_res[0] = make_result(EV_VALUE_BYTE, CH_SPACE, ERR_NONE);
                        step_res[1] = make_result(EV_VALUE_BYTE, c, ERR_NONE);
                        step_cnt    = 2'd2;
                    end else begin
                        step_res[0] = make_result(EV_VALUE_BYTE, c, ERR_NONE);
                        step_cnt    = 2'd1;
                    end
                    n_pend        = 1'b0;
                    n_value_count = val_next[LENGTH_BITS-1:0];
                end else begin
                    step_res[0] = make_result(EV_ERROR, '0,
                                              !c_ctrl ? ERR_VALUE_LONG :
                                              (c == CH_LF) ? ERR_BARE_LF : ERR_BAD_VALUE);
                    step_cnt      = 2'd1;
                    n_phase       = PH_LINE;
                    n_key_count   = '0;
                    n_value_count = '0;
                    n_pend = 1'b0;
                    n_prev = 1'b0;
                end
            end
            PH_VALUE_CR: begin
                if (c == CH_LF) begin
                    n_phase = PH_AFTER_LF;
                end else begin
                    step_res[0]   = make_result(EV_ERROR, '0, ERR_NO_LF);
                    step_cnt      = 2'd1;
                    n_phase       = PH_LINE;
                    n_key_count   = '0;
                    n_value_count = '0;
                    n_pend = 1'b0;
                    n_prev = 1'b0;
                end
            end
            PH_AFTER_LF: begin
                if (c_ws) begin
                    n_pend  = (r_value_count != '0);
                    n_phase = PH_VALUE;
                end else begin
                    step_res[0] = make_result(EV_FIELD_END, '0, ERR_NONE);
                    step_cnt    = 2'd1;
                    do_ls       = 1'b1;
                end
            end
            default: begin
                do_ls = 1'b1;
            end
        endcase

        if (do_ls) begin
            n_key_count   = '0;
            n_value_count = '0;
            n_pend        = 1'b0;
            n_prev        = 1'b0;
            if (c == CH_CR) begin
                n_phase = PH_BLOCK_CR;
            end else if (c_tchar && !ls_key_long) begin
                n_phase = PH_KEY;
                n_key_count = LENGTH_BITS'(1);
                n_prev      = c_letter;
                step_res[step_cnt[0]] = make_result(EV_KEY_BYTE, ls_key_out, ERR_NONE);
                step_cnt = step_cnt + 2'd1;
            end else begin
                n_phase = PH_LINE;
                step_res[step_cnt[0]] = make_result(EV_ERROR, '0,
                                                    c_tchar ? ERR_KEY_LONG :
                                                    (c == CH_LF) ? ERR_BARE_LF :
                                                    ERR_BAD_REQUEST);
                step_cnt = step_cnt + 2'd1;
            end
        end

        if (step_cnt != 2'd0) begin
            step_res[step_cnt[1]].last = 1'b1;
        end
    end

    assign pop  = (r_q_cnt != 2'd0) && o_out.ready;
    assign fire = r_in_valid && (step_cnt <= (2'd2 - r_q_cnt));
    assign base = r_q_cnt - {1'b0, pop};

    always_comb begin
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        if (pop) begin
            n_q[0] = r_q[1];
        end
        if (fire && (step_cnt != 2'd0)) begin
            n_q[base[0]] = step_res[0];
            if (step_cnt == 2'd2) begin
                n_q[1] = step_res[1];
            end
        end
        n_q_cnt = fire ? (base + step_cnt) : base;
    end

    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_q_cnt       <= 2'd0;
            r_phase       <= PH_LINE;
            r_key_count   <= '0;
            r_value_count <= '0;
            r_pend        <= 1'b0;
            r_prev        <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_phase       <= n_phase;
                r_key_count   <= n_key_count;
                r_value_count <= n_value_count;
                r_pend        <= n_pend;
                r_prev        <= n_prev;
            end
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    assign o_out.valid       = (r_q_cnt != 2'd0);
    assign o_out.event_kind  = r_q[0].kind;
    assign o_out.out_byte    = r_q[0].data;
    assign o_out.error_code  = r_q[0].err;
    assign o_out.last_of_run = r_q[0].last;

endmodule

FILE: sv/hhbp_checker.sv
module hhbp_checker import hhbp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [2:0]        i_event_kind,
    input logic [BYTE_W-1:0] i_out_byte,
    input logic [2:0]        i_error_code,
    input logic              i_last_of_run
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_event_kind, i_out_byte, i_error_code, i_last_of_run}))
        else $error("stalled result changed");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_event_kind == EV_ERROR) == (i_error_code != ERR_NONE)))
        else $error("error code does not match event kind");

    a_terminal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_kind == EV_KEY_END || i_event_kind == EV_BLOCK_END ||
                        i_event_kind == EV_ERROR)
        |-> i_last_of_run && (i_out_byte == '0))
        else $error("terminal event not last or carries a byte");

endmodule

bind http_header_block_parser hhbp_checker u_hhbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_event_kind  (o_out.event_kind),
    .i_out_byte    (o_out.out_byte),
    .i_error_code  (o_out.error_code),
    .i_last_of_run (o_out.last_of_run)
);

FILE: sim/hhbp_tb_pkg.sv
package hhbp_tb_pkg;
    import hhbp_pkg::*;

    localparam int unsigned COUNT_CAP = (1 << LENGTH_BITS_DEF) - 1;

    class parser_event_check;
        t_result     pending_events[$];
        t_result     step_events[$];
        int unsigned key_limit;
        int unsigned value_limit;
        t_phase      phase;
        int unsigned key_count;
        int unsigned value_count;
        bit          space_due;
        bit          after_letter;
        int unsigned mismatches;
        int unsigned bytes_parsed;
        int unsigned events_checked;
        int unsigned kind_tally[8];
        int unsigned error_tally[8];

        function new();
            key_limit   = KEY_LIMIT_RST;
            value_limit = VALUE_LIMIT_RST;
            start_block();
        endfunction

        function bit alpha(logic [7:0] c);
            return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        endfunction

        function bit token(logic [7:0] c);
            return alpha(c) || (c inside {[8'h30:8'h39]}) ||
                   (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                              8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E});
        endfunction

        function void start_block();
            phase        = PH_LINE;
            key_count    = 0;
            value_count  = 0;
            space_due    = 1'b0;
            after_letter = 1'b0;
        endfunction

        function void push(t_event k, logic [7:0] d, t_error e);
            t_result r;
            r.kind = k;
            r.data = d;
            r.err  = e;
            r.last = 1'b0;
            step_events = {step_events, r};
        endfunction

        function void abort(t_error e);
            push(EV_ERROR, 8'h00, e);
            start_block();
        endfunction

        function void set_limit(t_reg_index idx, logic [LIMIT_W-1:0] v);
            case (idx)
                REG_KEY_LIMIT:   key_limit = v;
                REG_VALUE_LIMIT: value_limit = v;
                default: ;
            endcase
        endfunction

        function void take_key_char(logic [7:0] c);
            int unsigned next_count;
            logic [7:0]  v;
            next_count = key_count + 1;
            v = c;
            if (next_count > key_limit || next_count > COUNT_CAP) begin
                abort(ERR_KEY_LONG);
                return;
            end
            key_count = next_count;
            if (alpha(c)) begin
                v = after_letter ? (c | CASE_BIT) : (c & ~CASE_BIT);
            end
            after_letter = alpha(c);
            push(EV_KEY_BYTE, v, ERR_NONE);
        endfunction

        function void begin_line(logic [7:0] c);
            key_count    = 0;
            value_count  = 0;
            space_due    = 1'b0;
            after_letter = 1'b0;
            if (c == CH_CR) begin
                phase = PH_BLOCK_CR;
            end else if (token(c)) begin
                phase = PH_KEY;
                take_key_char(c);
            end else if (c == CH_LF) begin
                abort(ERR_BARE_LF);
            end else begin
                abort(ERR_BAD_REQUEST);
            end
        endfunction

        function void take_value_char(logic [7:0] c);
            int unsigned next_count;
            if (c == CH_CR) begin
                phase = PH_VALUE_CR;
            end else if (c == CH_SPACE || c == CH_TAB) begin
                space_due = (value_count != 0);
            end else if (!(c < 8'h20 || c == CH_DEL)) begin
                next_count = value_count + 1 + (space_due ? 1 : 0);
                if (next_count > value_limit || next_count > COUNT_CAP) begin
                    abort(ERR_VALUE_LONG);
                    return;
                end
                if (space_due) push(EV_VALUE_BYTE, CH_SPACE, ERR_NONE);
                space_due   = 1'b0;
                value_count = next_count;
                push(EV_VALUE_BYTE, c, ERR_NONE);
            end else if (c == CH_LF) begin
                abort(ERR_BARE_LF);
            end else begin
                abort(ERR_BAD_VALUE);
            end
        endfunction

        function void parse_byte(logic [7:0] c);
            step_events.delete();
            bytes_parsed++;
            case (phase)
                PH_BLOCK_CR: begin
                    if (c == CH_LF) begin
                        push(EV_BLOCK_END, 8'h00, ERR_NONE);
                        start_block();
                    end else begin
                        abort(ERR_NO_LF);
                    end
                end
                PH_KEY: begin
                    if (c == CH_COLON) begin
                        push(EV_KEY_END, 8'h00, ERR_NONE);
                        phase       = PH_VALUE;
                        value_count = 0;
                        space_due   = 1'b0;
                    end else if (token(c)) begin
                        take_key_char(c);
                    end else begin
                        abort(ERR_BAD_KEY);
                    end
                end
                PH_VALUE: take_value_char(c);
                PH_VALUE_CR: begin
                    if (c == CH_LF) phase = PH_AFTER_LF;
                    else abort(ERR_NO_LF);
                end
                PH_AFTER_LF: begin
                    if (c == CH_SPACE || c == CH_TAB) begin
                        space_due = (value_count != 0);
                        phase     = PH_VALUE;
                    end else begin
                        push(EV_FIELD_END, 8'h00, ERR_NONE);
                        begin_line(c);
                    end
                end
                default: begin_line(c);
            endcase
            if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
            pending_events = {pending_events, step_events};
        endfunction

        function void match_event(t_result got);
            t_result want;
            events_checked++;
            kind_tally[got.kind]++;
            if (got.kind == EV_ERROR) error_tally[got.err]++;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: kind %0d byte %02h err %0d last %0b",
                             got.kind, got.data, got.err, got.last);
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind || got.data !== want.data ||
                got.err !== want.err || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected kind %0d byte %02h err %0d last %0b, %s",
                             want.kind, want.data, want.err, want.last,
                             $sformatf("got kind %0d byte %02h err %0d last %0b",
                                       got.kind, got.data, got.err, got.last));
            end
        endfunction

        function int unsigned outstanding();
            return pending_events.size();
        endfunction
    endclass

endpackage

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hhbp_pkg::*;
    import hhbp_tb_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_BYTES   = 190;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hhbp_cfg_if cfg_if ();
    hhbp_in_if  in_if ();
    hhbp_out_if out_if ();

    http_header_block_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    parser_event_check checker_q = new();

    int unsigned send_idle_pct = 32;
    int unsigned recv_idle_pct = 74;
    int unsigned bytes_sent    = 0;
    int unsigned key_lim       = KEY_LIMIT_RST;
    int unsigned val_lim       = VALUE_LIMIT_RST;

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) checker_q.parse_byte(in_if.in_byte);
            if (out_if.valid && out_if.ready) begin
                got.kind = t_event'(out_if.event_kind);
                got.data = out_if.out_byte;
                got.err  = t_error'(out_if.error_code);
                got.last = out_if.last_of_run;
                checker_q.match_event(got);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic stop_bytes();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic settle();
        while (checker_q.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input t_reg_index idx, input logic [LIMIT_W-1:0] v);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        checker_q.set_limit(idx, v);
        if (idx == REG_KEY_LIMIT) key_lim = v;
        else val_lim = v;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] key_char();
        string      extra = "0123456789!#$%&'*+-.^_`|~";
        logic [7:0] base;
        if ($urandom_range(99) < 70) begin
            base = $urandom_range(1) ? 8'h41 : 8'h61;
            return base + 8'($urandom_range(25));
        end
        return extra[$urandom_range(extra.len() - 1)];
    endfunction

    function automatic logic [7:0] value_char();
        if ($urandom_range(99) < 80) return 8'($urandom_range(8'h7E, 8'h21));
        return 8'($urandom_range(8'hFF, 8'h80));
    endfunction

    function automatic logic [7:0] blank();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    task automatic send_block();
        logic [7:0]  blk[$];
        int unsigned fields;
        int unsigned words;
        int unsigned key_cap;
        int unsigned word_cap;
        key_cap  = (key_lim < 10) ? key_lim + 1 : 10;
        word_cap = (val_lim < 8) ? val_lim + 1 : 8;
        if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(8, 1)) blk = {blk, 8'($urandom_range(255))};
        end else begin
            fields = $urandom_range(4);
            repeat (fields) begin
                repeat ($urandom_range(key_cap, 1)) blk = {blk, key_char()};
                blk = {blk, CH_COLON};
                repeat ($urandom_range(2)) blk = {blk, blank()};
                words = $urandom_range(3);
                for (int w = 0; w < words; w++) begin
                    if (w > 0) begin
                        if ($urandom_range(99) < 20) begin
                            blk = {blk, CH_CR, CH_LF};
                        end
                        repeat ($urandom_range(2, 1)) blk = {blk, blank()};
                    end
                    repeat ($urandom_range(word_cap, 1)) blk = {blk, value_char()};
                end
                repeat ($urandom_range(1)) blk = {blk, blank()};
                blk = {blk, CH_CR, CH_LF};
            end
            blk = {blk, CH_CR, CH_LF};
        end
        foreach (blk[i]) begin
            if ($urandom_range(99) < 2) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                if ($urandom_range(99) < 1) send_byte(8'($urandom_range(255)));
                send_byte(blk[i]);
            end
        end
    endtask

    initial begin
        int unsigned target;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = REG_KEY_LIMIT;
        cfg_if.data   = '0;
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        out_if.ready  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        write_limit(REG_KEY_LIMIT, 16'd2);
        write_limit(REG_VALUE_LIMIT, 16'd3);

        // fold in a value, then a folded line's byte runs past the value limit
        send_text("aB:");
        send_text(" x");
        send_byte(CH_TAB);
        send_text(" y");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_TAB);
        send_text("z");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("abc");
        // high byte in a value, then field end followed by a key byte
        send_text("x:");
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("!");
        send_byte(8'h00);
        send_byte(CH_SPACE);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_text("0");
        send_text("q:");
        send_byte(CH_DEL);
        send_text("k:");
        send_byte(CH_LF);
        stop_bytes();
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_idle_pct = 32;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (p)
                0: begin
                    write_limit(REG_KEY_LIMIT, 16'd1);
                    write_limit(REG_VALUE_LIMIT, 16'd1);
                end
                1: begin
                    write_limit(REG_KEY_LIMIT, 16'hFFFF);
                    write_limit(REG_VALUE_LIMIT, 16'hFFFF);
                end
                2: begin
                    write_limit(REG_KEY_LIMIT, 16'($urandom_range(12, 2)));
                    write_limit(REG_VALUE_LIMIT, 16'($urandom_range(12, 2)));
                end
                3: begin
                    write_limit(REG_KEY_LIMIT, 16'hFFFF);
                    write_limit(REG_VALUE_LIMIT, 16'd1);
                end
                4: begin
                    write_limit(REG_KEY_LIMIT, KEY_LIMIT_RST);
                    write_limit(REG_VALUE_LIMIT, VALUE_LIMIT_RST);
                end
                default: begin
                    write_limit(REG_KEY_LIMIT, 16'($urandom_range(8, 1)));
                    write_limit(REG_VALUE_LIMIT, 16'($urandom_range(30, 3)));
                end
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) send_block();
            stop_bytes();
            settle();
        end

        $display("%0d header bytes over 7 limit settings and 3 flow-control mixes, %0d events",
                 bytes_sent, checker_q.events_checked);
        $display("key %0d, key end %0d, value %0d, field end %0d, block end %0d, errors %0d",
                 checker_q.kind_tally[EV_KEY_BYTE], checker_q.kind_tally[EV_KEY_END],
                 checker_q.kind_tally[EV_VALUE_BYTE], checker_q.kind_tally[EV_FIELD_END],
                 checker_q.kind_tally[EV_BLOCK_END], checker_q.kind_tally[EV_ERROR]);
        if (checker_q.mismatches == 0 && checker_q.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
